@@ hw/rtl/dasb_pkg.sv @@
// Shared constants and codes for the delay-and-sum beamformer.
package dasb_pkg;

  // Fixed field widths
  localparam int BAND_IN_W = 4;
  localparam int POS_IN_W  = 10;
  localparam int BEAM_W    = 7;
  localparam int FL_W      = 11;
  localparam int BPS_W     = 6;
  localparam int LAG_W     = 6;
  localparam int DIFF_W    = BEAM_W + 1;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam int MIN_FRAME        = 2;
  localparam int FL_RESET         = 1024;
  localparam int BPS_RESET        = 4;

  // Register indexes (paddr[2])
  localparam logic REG_FRAME_LENGTH   = 1'b0;
  localparam logic REG_BEAMS_PER_SIDE = 1'b1;

  // Request types
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // Status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

endpackage

@@ hw/rtl/dasb_front.sv @@
// Front end: range checks, lag split and command packing for each request.
module dasb_front #(
  parameter int BANDS       = 16,
  parameter int MAX_FRAME   = 1024,
  parameter int SAMPLE_BITS = 16,
  parameter int LEN_W       = 11,
  parameter int POS_W       = 10,
  parameter int ADDR_W      = 14,
  parameter int CMD_W       = 9 + ADDR_W + POS_W + 2 * SAMPLE_BITS
) (
  input  logic [dasb_pkg::FL_W-1:0]      frame_length,
  input  logic [dasb_pkg::BPS_W-1:0]     beams_per_side,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           req_type,
  input  logic [dasb_pkg::BAND_IN_W-1:0] band_index,
  input  logic [dasb_pkg::POS_IN_W-1:0]  sample_position,
  input  logic [dasb_pkg::BEAM_W-1:0]    beam_index,
  input  logic signed [SAMPLE_BITS-1:0]  first_channel_sample,
  input  logic signed [SAMPLE_BITS-1:0]  second_channel_sample,
  input  logic                           q_full,
  output logic                           q_push,
  output logic [CMD_W-1:0]               q_data,
  output logic [LEN_W-1:0]               eff_len
);
  import dasb_pkg::*;

  typedef struct packed {
    logic                   is_write;
    logic                   err;
    logic [ADDR_W-1:0]      base;
    logic [POS_W-1:0]       pos;
    logic                   lag_neg;
    logic [LAG_W-1:0]       lag_mag;
    logic [SAMPLE_BITS-1:0] s1;
    logic [SAMPLE_BITS-1:0] s2;
  } cmd_t;

  cmd_t              cmd;
  logic [DIFF_W-1:0] nbeams;
  logic [DIFF_W-1:0] lag_diff;
  logic [DIFF_W-1:0] lag_abs;
  logic              band_ok;
  logic              pos_ok;
  logic              beam_ok;
  logic              err;

  // Frame length saturates into [2, MAX_FRAME]
  always_comb begin
    if (frame_length < FL_W'(MIN_FRAME)) begin
      eff_len = LEN_W'(MIN_FRAME);
    end else if (32'(frame_length) > MAX_FRAME) begin
      eff_len = LEN_W'(MAX_FRAME);
    end else begin
      eff_len = LEN_W'(frame_length);
    end
  end

  assign nbeams   = {1'b0, beams_per_side, 1'b1};
  assign band_ok  = 32'(band_index) < BANDS;
  assign pos_ok   = 32'(sample_position) < 32'(eff_len);
  assign beam_ok  = {1'b0, beam_index} < nbeams;
  assign err      = !(band_ok && pos_ok && (req_type == REQ_WRITE || beam_ok));

  assign lag_diff = {1'b0, beam_index} - {2'b00, beams_per_side};
  assign lag_abs  = lag_diff[DIFF_W-1] ? (DIFF_W'(0) - lag_diff) : lag_diff;

  always_comb begin
    cmd.is_write = (req_type == REQ_WRITE);
    cmd.err      = err;
    cmd.base     = ADDR_W'(32'(band_index) * MAX_FRAME);
    cmd.pos      = POS_W'(sample_position);
    cmd.lag_neg  = lag_diff[DIFF_W-1];
    cmd.lag_mag  = lag_abs[LAG_W-1:0];
    cmd.s1       = first_channel_sample;
    cmd.s2       = second_channel_sample;
  end

  // Out-of-range writes are dropped here; they have no result
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && !(req_type == REQ_WRITE && err);
  assign q_data   = CMD_W'(cmd);

endmodule

@@ hw/rtl/dasb_queue.sv @@
// Two-entry command queue between front and back.
module dasb_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty
);
  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ hw/rtl/dasb_back.sv @@
// Back end: sample stores, lag wrap sequencer, beam add and output register.
module dasb_back #(
  parameter int BANDS       = 16,
  parameter int MAX_FRAME   = 1024,
  parameter int SAMPLE_BITS = 16,
  parameter int LEN_W       = 11,
  parameter int POS_W       = 10,
  parameter int ADDR_W      = 14,
  parameter int CMD_W       = 9 + ADDR_W + POS_W + 2 * SAMPLE_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [LEN_W-1:0]            eff_len,
  input  logic                        q_empty,
  input  logic [CMD_W-1:0]            q_head,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [SAMPLE_BITS:0] beam_sum,
  output logic                        status
);
  import dasb_pkg::*;

  localparam int DEPTH  = BANDS * MAX_FRAME;
  localparam int D_W    = LEN_W + LAG_W - 1;
  localparam int SUM_W  = LEN_W + 1;

  typedef struct packed {
    logic                   is_write;
    logic                   err;
    logic [ADDR_W-1:0]      base;
    logic [POS_W-1:0]       pos;
    logic                   lag_neg;
    logic [LAG_W-1:0]       lag_mag;
    logic [SAMPLE_BITS-1:0] s1;
    logic [SAMPLE_BITS-1:0] s2;
  } cmd_t;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_REDUCE = 6'b000010,
    S_WRAP   = 6'b000100,
    S_READ   = 6'b001000,
    S_SUM    = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  logic [SAMPLE_BITS-1:0] store1 [DEPTH];
  logic [SAMPLE_BITS-1:0] store2 [DEPTH];

  state_t                 state;
  state_t                 state_next;
  cmd_t                   cmd;
  logic [ADDR_W-1:0]      head_addr;
  logic                   wr_en;
  logic [ADDR_W-1:0]      addr1;
  logic [ADDR_W-1:0]      addr2;
  logic [ADDR_W-1:0]      base_q;
  logic [POS_W-1:0]       pos_q;
  logic                   neg_q;
  logic [LAG_W-1:0]       rem;
  logic [D_W-1:0]         divisor;
  logic [2:0]             step;
  logic [SAMPLE_BITS-1:0] rd1;
  logic [SAMPLE_BITS-1:0] rd2;
  logic [SUM_W-1:0]       pos_x;
  logic [SUM_W-1:0]       rem_x;
  logic [SUM_W-1:0]       len_x;
  logic [SUM_W-1:0]       up;
  logic [SUM_W-1:0]       wrapped;

  assign cmd       = cmd_t'(q_head);
  assign head_addr = cmd.base + ADDR_W'(cmd.pos);
  assign q_pop     = (state == S_IDLE) && !q_empty;
  assign wr_en     = q_pop && cmd.is_write;
  assign out_valid = (state == S_OUT);

  // Stores: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store1[head_addr] <= cmd.s1;
    end
    if (state == S_READ) begin
      rd1 <= store1[addr1];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store2[head_addr] <= cmd.s2;
    end
    if (state == S_READ) begin
      rd2 <= store2[addr2];
    end
  end

  // Circular wrap of pos +/- (lag mod len); rem < len here
  assign pos_x = SUM_W'(pos_q);
  assign rem_x = SUM_W'(rem);
  assign len_x = SUM_W'(eff_len);
  assign up    = pos_x + rem_x;

  always_comb begin
    if (!neg_q) begin
      wrapped = (up >= len_x) ? (up - len_x) : up;
    end else begin
      wrapped = (pos_x >= rem_x) ? (pos_x - rem_x) : (pos_x + len_x - rem_x);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (q_pop && !cmd.is_write) begin
          state_next = cmd.err ? S_OUT : S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (step == 3'(LAG_W - 1)) begin
          state_next = S_WRAP;
        end
      end
      S_WRAP:   state_next = S_READ;
      S_READ:   state_next = S_SUM;
      S_SUM:    state_next = S_OUT;
      S_OUT: begin
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        base_q  <= cmd.base;
        pos_q   <= cmd.pos;
        neg_q   <= cmd.lag_neg;
        addr1   <= head_addr;
        rem     <= cmd.lag_mag;
        divisor <= D_W'(eff_len) << (LAG_W - 1);
        step    <= 3'd0;
        if (cmd.err) begin
          beam_sum <= '0;
          status   <= STATUS_ERR;
        end
      end
      S_REDUCE: begin
        // restoring reduction, one bit of the quotient per cycle
        if (D_W'(rem) >= divisor) begin
          rem <= rem - LAG_W'(divisor);
        end
        divisor <= divisor >> 1;
        step    <= step + 3'd1;
      end
      S_WRAP: begin
        addr2 <= base_q + ADDR_W'(wrapped[POS_W-1:0]);
      end
      S_READ: begin
      end
      S_SUM: begin
        beam_sum <= $signed({rd1[SAMPLE_BITS-1], rd1}) + $signed({rd2[SAMPLE_BITS-1], rd2});
        status   <= STATUS_OK;
      end
      S_OUT: begin
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hw/rtl/delay_and_sum_beamformer.sv @@
// Top level of the two-channel delay-and-sum beamformer with its register port.
// Two-channel delay-and-sum beamformer. A write beat (req_type 0) stores a
// sample pair at band/position; it gives no result, and one that is out of
// range is dropped. A read beat (req_type 1) returns the first-channel sample
// at the position plus the second-channel sample at the position shifted by
// beam_index - beams_per_side, wrapped within the frame length (clamped to
// 2..MAX_FRAME). A band, position or beam out of range returns status 1 with
// a zero sum. Timing: the front checks each beat and queues it (two entries);
// the back retires one write per cycle, while a read holds the back through
// pop, the restoring lag-mod-length loop, wrap, store read, add and output,
// plus any output stall, and a read in error holds it through pop and output.
// Sample stores hold no reset value; read only what was written.
// Registers: frame_length at 0x0 (reset 1024), beams_per_side at 0x4 (reset 4);
// write them only while the block is idle.
module delay_and_sum_beamformer #(
  parameter int BANDS       = 16,
  parameter int MAX_FRAME   = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  // register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dasb_pkg::PADDR_W-1:0]   paddr,
  input  logic [dasb_pkg::PDATA_W-1:0]   pwdata,
  output logic [dasb_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  // request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           req_type,
  input  logic [dasb_pkg::BAND_IN_W-1:0] band_index,
  input  logic [dasb_pkg::POS_IN_W-1:0]  sample_position,
  input  logic [dasb_pkg::BEAM_W-1:0]    beam_index,
  input  logic signed [SAMPLE_BITS-1:0]  first_channel_sample,
  input  logic signed [SAMPLE_BITS-1:0]  second_channel_sample,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_BITS:0]    beam_sum,
  output logic                           status
);
  import dasb_pkg::*;

  localparam int LEN_W  = $clog2(MAX_FRAME + 1);
  localparam int POS_W  = $clog2(MAX_FRAME);
  localparam int ADDR_W = $clog2(BANDS * MAX_FRAME);
  // wr, err, base, pos, lag sign, lag magnitude, two samples
  localparam int CMD_W  = 3 + LAG_W + ADDR_W + POS_W + 2 * SAMPLE_BITS;

  logic [FL_W-1:0]  frame_length;
  logic [BPS_W-1:0] beams_per_side;
  logic             reg_wr;
  logic [LEN_W-1:0] eff_len;
  logic             q_push;
  logic [CMD_W-1:0] q_data;
  logic             q_full;
  logic             q_pop;
  logic [CMD_W-1:0] q_head;
  logic             q_empty;

  // Register port: no wait states; decode on the word index only
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length   <= FL_W'(FL_RESET);
      beams_per_side <= BPS_W'(BPS_RESET);
    end else if (reg_wr) begin
      unique case (paddr[2])
        REG_FRAME_LENGTH:   frame_length   <= pwdata[FL_W-1:0];
        REG_BEAMS_PER_SIDE: beams_per_side <= pwdata[BPS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FRAME_LENGTH:   prdata = PDATA_W'(frame_length);
      REG_BEAMS_PER_SIDE: prdata = PDATA_W'(beams_per_side);
      default:            prdata = '0;
    endcase
  end

  // Front: range checks and command build
  dasb_front #(
    .BANDS       (BANDS),
    .MAX_FRAME   (MAX_FRAME),
    .SAMPLE_BITS (SAMPLE_BITS),
    .LEN_W       (LEN_W),
    .POS_W       (POS_W),
    .ADDR_W      (ADDR_W),
    .CMD_W       (CMD_W)
  ) u_front (
    .frame_length          (frame_length),
    .beams_per_side        (beams_per_side),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .req_type              (req_type),
    .band_index            (band_index),
    .sample_position       (sample_position),
    .beam_index            (beam_index),
    .first_channel_sample  (first_channel_sample),
    .second_channel_sample (second_channel_sample),
    .q_full                (q_full),
    .q_push                (q_push),
    .q_data                (q_data),
    .eff_len               (eff_len)
  );

  // Queue decouples front acceptance from back processing
  dasb_queue #(
    .WIDTH (CMD_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // Back: stores, lag wrap, sum, output register
  dasb_back #(
    .BANDS       (BANDS),
    .MAX_FRAME   (MAX_FRAME),
    .SAMPLE_BITS (SAMPLE_BITS),
    .LEN_W       (LEN_W),
    .POS_W       (POS_W),
    .ADDR_W      (ADDR_W),
    .CMD_W       (CMD_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .eff_len   (eff_len),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .beam_sum  (beam_sum),
    .status    (status)
  );

endmodule
